[rtl/core/mpwm_pkg.sv]
// ----------------------------------------------------------------------------
// mpwm_pkg: shared types and constants of the multichannel PWM with fade
// Item modes, sequencer states, register indexes and the fade arithmetic
// constants used by the core and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package mpwm_pkg;

  localparam int DEF_CHANNELS = 8;

  // Field widths of one input item and one result item.
  localparam int MODE_W  = 2;
  localparam int CHAN_W  = 3;
  localparam int LEVEL_W = 9;
  localparam int OUT_W   = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int PLEN_W     = 9;
  localparam int CCOUNT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;

  localparam logic [PLEN_W-1:0]   PLEN_RESET   = 9'd256;
  localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 4'd0;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 9'd256;
  localparam logic [7:0]         FADE_STEPS  = 8'd255;

  // x / 254 == (x * 66053) >> 24 for every x below 65536.
  localparam int              RECIP_W     = 17;
  localparam logic [16:0]     RECIP_254   = 17'd66053;
  localparam int              RECIP_SHIFT = 24;

  typedef enum logic [1:0] {
    MODE_TICK       = 2'd0,
    MODE_SET_LEVEL  = 2'd1,
    MODE_START_FADE = 2'd2,
    MODE_FADE_STEP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // Control group from the sequencer's output decode.
  typedef struct packed {
    logic in_ready;
    logic exec;
    logic mul;
    logic div;
    logic load_out;
  } ctrl_t;

endpackage

`default_nettype wire

[rtl/core/mpwm_in_if.sv]
// ----------------------------------------------------------------------------
// mpwm_in_if: input item channel
// Valid/ready channel carrying mode, channel index and level value.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpwm_in_if;
  logic                           valid;
  logic                           ready;
  logic [mpwm_pkg::MODE_W-1:0]    mode;
  logic [mpwm_pkg::CHAN_W-1:0]    channel;
  logic [mpwm_pkg::LEVEL_W-1:0]   level_value;

  modport source (output valid, output mode, output channel, output level_value,
                  input ready);
  modport sink   (input valid, input mode, input channel, input level_value,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/mpwm_out_if.sv]
// ----------------------------------------------------------------------------
// mpwm_out_if: result item channel
// Valid/ready channel carrying the channel output bits and the fade flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpwm_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpwm_pkg::OUT_W-1:0]   channel_outputs;
  logic                         fade_done;

  modport source (output valid, output channel_outputs, output fade_done,
                  input ready);
  modport sink   (input valid, input channel_outputs, input fade_done,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/multichannel_pwm_with_fade.sv]
// ----------------------------------------------------------------------------
// multichannel_pwm_with_fade: multichannel PWM generator with linear fade
// Period counter, per-channel levels latched at period start, and a fade
// engine that walks the enabled channels through one shared multiplier.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  in_chan   sink       mode, channel, level_value
//  out_chan  source     channel_outputs, fade_done
//  cfg_*     write      period_length (index 0), channel_count (index 1)
//
// A tick, set level or start fade item goes from EXEC to DONE. A fade step
// that moves the levels visits MUL then DIV for each enabled channel: each
// channel uses the shared multiplier twice, once for step*(target-start) and
// once for the reciprocal multiply that divides by 254. A fade step that
// finds the fade finished goes from EXEC to DONE. Reset is synchronous and
// puts every level at zero with no fade running. A new item is taken while
// a result waits in the output register; a stalled output holds the
// sequencer in its final state until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_pwm_with_fade #(
  parameter int CHANNELS = mpwm_pkg::DEF_CHANNELS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  mpwm_in_if.sink                             in_chan,
  mpwm_out_if.source                          out_chan,
  input  wire                                 cfg_we,
  input  wire [mpwm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [mpwm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int CMP_W  = (CNT_W > mpwm_pkg::CCOUNT_W) ? CNT_W : mpwm_pkg::CCOUNT_W;
  localparam int OUT_CH = (CHANNELS < mpwm_pkg::OUT_W) ? CHANNELS : mpwm_pkg::OUT_W;
  localparam int MUL_A_W = 16;
  localparam int MUL_P_W = MUL_A_W + mpwm_pkg::RECIP_W;

  // Configuration registers.
  logic [mpwm_pkg::PLEN_W-1:0]   plen_r;
  logic [mpwm_pkg::CCOUNT_W-1:0] ccount_r;

  // Block state.
  mpwm_pkg::state_t state_r, state_nxt;
  mpwm_pkg::ctrl_t  ctrl;

  logic [1:0]                       mode_r;
  logic [mpwm_pkg::CHAN_W-1:0]      ch_r;
  logic [mpwm_pkg::LEVEL_W-1:0]     val_r;

  logic [7:0]                       period_cnt_r;
  logic [mpwm_pkg::LEVEL_W-1:0]     levels_r  [CHANNELS];
  logic [mpwm_pkg::LEVEL_W-1:0]     active_r  [CHANNELS];
  logic [7:0]                       starts_r  [CHANNELS];
  logic [7:0]                       targets_r [CHANNELS];
  logic [7:0]                       fade_pos_r;
  logic [mpwm_pkg::OUT_W-1:0]       out_bits_r;
  logic                             done_r;
  logic [IDX_W-1:0]                 idx_r;
  logic [MUL_A_W-1:0]               prod_r;
  logic                             neg_r;

  logic                             out_valid_r;
  logic [mpwm_pkg::OUT_W-1:0]       res_bits_r;
  logic                             res_done_r;

  // Effective configuration.
  logic [mpwm_pkg::PLEN_W-1:0]      eff_len;
  logic [CMP_W-1:0]                 ccount_ext;
  logic [CMP_W-1:0]                 cnt_eff;

  always_comb begin
    if (plen_r == '0) begin
      eff_len = mpwm_pkg::PLEN_W'(1);
    end else if (plen_r > mpwm_pkg::LEVEL_FULL) begin
      eff_len = mpwm_pkg::LEVEL_FULL;
    end else begin
      eff_len = plen_r;
    end
    ccount_ext = CMP_W'(ccount_r);
    cnt_eff    = (ccount_ext > CMP_W'(CHANNELS)) ? CMP_W'(CHANNELS) : ccount_ext;
  end

  // Tick: advance the counter, latch levels on wrap, compare every enabled channel.
  logic [8:0]                   cnt_inc;
  logic                         wrap;
  logic [7:0]                   cnt_new;
  logic [mpwm_pkg::LEVEL_W-1:0] active_src [CHANNELS];
  logic [mpwm_pkg::OUT_W-1:0]   tick_bits;

  always_comb begin
    cnt_inc = {1'b0, period_cnt_r} + 9'd1;
    wrap    = (cnt_inc >= eff_len);
    cnt_new = wrap ? 8'd0 : cnt_inc[7:0];
    for (int i = 0; i < CHANNELS; i++) begin
      active_src[i] = wrap ? levels_r[i] : active_r[i];
    end
    tick_bits = '0;
    for (int i = 0; i < OUT_CH; i++) begin
      tick_bits[i] = (cnt_eff > CMP_W'(i)) && ({1'b0, cnt_new} < active_src[i]);
    end
  end

  // Fade walk: the shared multiplier and the operands around it.
  logic [7:0]                 cur_start;
  logic [7:0]                 cur_target;
  logic [8:0]                 diff;
  logic [7:0]                 abs_diff;
  logic [MUL_A_W-1:0]         mul_a;
  logic [mpwm_pkg::RECIP_W-1:0] mul_b;
  logic [MUL_P_W-1:0]         mul_p;
  logic [8:0]                 quot;
  logic [7:0]                 fade_lvl;
  logic                       walk_last;
  logic                       fade_complete;
  logic [mpwm_pkg::LEVEL_W-1:0] set_lvl;

  always_comb begin
    cur_start  = starts_r[idx_r];
    cur_target = targets_r[idx_r];
    diff       = {1'b0, cur_target} - {1'b0, cur_start};
    abs_diff   = diff[8] ? 8'(-diff) : diff[7:0];
    if (ctrl.div) begin
      mul_a = prod_r;
      mul_b = mpwm_pkg::RECIP_254;
    end else begin
      mul_a = MUL_A_W'(fade_pos_r);
      mul_b = mpwm_pkg::RECIP_W'(abs_diff);
    end
    mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    quot     = mul_p[mpwm_pkg::RECIP_SHIFT +: 9];
    fade_lvl = neg_r ? (cur_start - quot[7:0]) : (cur_start + quot[7:0]);
    walk_last     = ((CMP_W'(idx_r) + CMP_W'(1)) >= cnt_eff);
    fade_complete = (fade_pos_r == mpwm_pkg::FADE_STEPS);
    set_lvl = (val_r > mpwm_pkg::LEVEL_FULL) ? mpwm_pkg::LEVEL_FULL : val_r;
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpwm_pkg::ST_IDLE: begin
        if (in_chan.valid) state_nxt = mpwm_pkg::ST_EXEC;
      end
      mpwm_pkg::ST_EXEC: begin
        if (mode_r == mpwm_pkg::MODE_FADE_STEP && !fade_complete && cnt_eff != '0) begin
          state_nxt = mpwm_pkg::ST_MUL;
        end else begin
          state_nxt = mpwm_pkg::ST_DONE;
        end
      end
      mpwm_pkg::ST_MUL: state_nxt = mpwm_pkg::ST_DIV;
      mpwm_pkg::ST_DIV: begin
        state_nxt = walk_last ? mpwm_pkg::ST_DONE : mpwm_pkg::ST_MUL;
      end
      mpwm_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) state_nxt = mpwm_pkg::ST_IDLE;
      end
      default: state_nxt = mpwm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: output decode.
  always_comb begin
    ctrl = '0;
    case (state_r)
      mpwm_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      mpwm_pkg::ST_EXEC: ctrl.exec     = 1'b1;
      mpwm_pkg::ST_MUL:  ctrl.mul      = 1'b1;
      mpwm_pkg::ST_DIV:  ctrl.div      = 1'b1;
      mpwm_pkg::ST_DONE: ctrl.load_out = !out_valid_r || out_chan.ready;
      default:           ctrl = '0;
    endcase
  end

  assign in_chan.ready            = ctrl.in_ready;
  assign out_chan.valid           = out_valid_r;
  assign out_chan.channel_outputs = res_bits_r;
  assign out_chan.fade_done       = res_done_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r   <= mpwm_pkg::PLEN_RESET;
      ccount_r <= mpwm_pkg::CCOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mpwm_pkg::CFG_PERIOD_LENGTH: plen_r   <= cfg_data;
        mpwm_pkg::CFG_CHANNEL_COUNT: ccount_r <= cfg_data[mpwm_pkg::CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (in_chan.valid && ctrl.in_ready) begin
      mode_r <= in_chan.mode;
      ch_r   <= in_chan.channel;
      val_r  <= in_chan.level_value;
    end
  end

  // Datapath state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_cnt_r <= 8'(mpwm_pkg::PLEN_RESET - mpwm_pkg::PLEN_W'(1));
      for (int i = 0; i < CHANNELS; i++) begin
        levels_r[i]  <= '0;
        active_r[i]  <= '0;
        starts_r[i]  <= '0;
        targets_r[i] <= '0;
      end
      fade_pos_r <= mpwm_pkg::FADE_STEPS;
      out_bits_r <= '0;
      done_r     <= 1'b0;
      idx_r      <= '0;
      neg_r      <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        done_r <= 1'b0;
        idx_r  <= '0;
        case (mode_r)
          mpwm_pkg::MODE_TICK: begin
            period_cnt_r <= cnt_new;
            out_bits_r   <= tick_bits;
            if (wrap) begin
              for (int i = 0; i < CHANNELS; i++) active_r[i] <= levels_r[i];
            end
          end
          mpwm_pkg::MODE_SET_LEVEL: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (int'(ch_r) == i) begin
                levels_r[i]  <= set_lvl;
                starts_r[i]  <= set_lvl[7:0];
                targets_r[i] <= set_lvl[7:0];
              end
            end
          end
          mpwm_pkg::MODE_START_FADE: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (int'(ch_r) == i) targets_r[i] <= val_r[7:0];
              if (cnt_eff > CMP_W'(i)) starts_r[i] <= levels_r[i][7:0];
            end
            fade_pos_r <= '0;
          end
          mpwm_pkg::MODE_FADE_STEP: begin
            if (fade_complete) begin
              done_r <= 1'b1;
            end else if (cnt_eff == '0) begin
              // No enabled channel: the step still counts.
              fade_pos_r <= fade_pos_r + 8'd1;
            end
          end
          default: ;
        endcase
      end
      if (ctrl.mul) begin
        prod_r <= mul_p[MUL_A_W-1:0];
        neg_r  <= diff[8];
      end
      if (ctrl.div) begin
        levels_r[idx_r] <= {1'b0, fade_lvl};
        if (walk_last) begin
          fade_pos_r <= fade_pos_r + 8'd1;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
    end
  end

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpwm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      res_bits_r <= out_bits_r;
      res_done_r <= done_r;
    end
  end

  // The fade walk never runs past the enabled channels.
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.mul || ctrl.div) |-> (CMP_W'(idx_r) < cnt_eff))
    else $error("fade walk index beyond enabled channels");

  // Finishing the last channel advances the fade by exactly one step.
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.div && walk_last) |=> (fade_pos_r == 8'($past(fade_pos_r) + 8'd1)))
    else $error("fade position did not advance after the walk");

  // A completion report only comes from a finished fade.
  a_done_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.exec && mode_r == mpwm_pkg::MODE_FADE_STEP && !fade_complete) |=> !done_r)
    else $error("fade done flagged while a fade is running");

endmodule

`default_nettype wire
